/* rtl/emst_pkg.sv */
// ----------------------------------------------------------------------------
// emst_pkg
// Shared types and fixed constants of the Euclidean MST block: register
// map of the configuration port and the controller command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package emst_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT   = 2'd1;

  // register widths and reset values
  localparam int PC_W = 7;
  localparam int DC_W = 4;
  localparam logic [PC_W-1:0] PC_RESET = 7'd2;
  localparam logic [DC_W-1:0] DC_RESET = 4'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // store one coordinate beat
    logic round0;   // set up first round from point 0
    logic cap_q;    // capture candidate point of position p
    logic step_j;   // accumulate one squared coordinate difference
    logic cmp;      // relax candidate and track minimum
    logic emit;     // issue edge, swap, advance to next round
  } emst_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic load_last; // current load beat completes the set
    logic np_one;    // set holds a single point
    logic j_last;    // last coordinate of the distance
    logic p_last;    // last position of the round
    logic s_last;    // last round
  } emst_stat_t;

endpackage

`default_nettype wire

/* rtl/emst_ctrl.sv */
// ----------------------------------------------------------------------------
// emst_ctrl
// Sequencer of the Euclidean MST block: loads beats while idle, then walks
// the Prim rounds position by position and coordinate by coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module emst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire emst_pkg::emst_stat_t stat,
  output emst_pkg::emst_cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_VO   = 3'd1;
  localparam logic [2:0] ST_Q    = 3'd2;
  localparam logic [2:0] ST_CA   = 3'd3;
  localparam logic [2:0] ST_CB   = 3'd4;
  localparam logic [2:0] ST_CC   = 3'd5;
  localparam logic [2:0] ST_CD   = 3'd6;
  localparam logic [2:0] ST_CMP  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       emit_r, emit_nxt;

  assign busy = (state_r != ST_IDLE) || emit_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    emit_nxt  = 1'b0;
    cmd       = '0;
    if (emit_r) begin
      // edge cycle: swap, then next round or done
      cmd.emit = 1'b1;
      state_nxt = stat.s_last ? ST_IDLE : ST_VO;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            cmd.load = 1'b1;
            if (stat.load_last && !stat.np_one) begin
              cmd.round0 = 1'b1;
              state_nxt  = ST_VO;
            end
          end
        end
        ST_VO:  state_nxt = ST_Q;
        ST_Q: begin
          cmd.cap_q = 1'b1;
          state_nxt = ST_CA;
        end
        ST_CA:  state_nxt = ST_CB;
        ST_CB:  state_nxt = ST_CC;
        ST_CC:  state_nxt = ST_CD;
        ST_CD: begin
          cmd.step_j = 1'b1;
          state_nxt  = stat.j_last ? ST_CMP : ST_CA;
        end
        ST_CMP: begin
          cmd.cmp = 1'b1;
          if (stat.p_last) begin
            emit_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_VO;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/emst_dp.sv */
// ----------------------------------------------------------------------------
// emst_dp
// Datapath of the Euclidean MST block: coordinate store, best-distance and
// parent stores, visit-order permutation, distance accumulator and the
// running minimum of a round.
// ----------------------------------------------------------------------------
`default_nettype none

module emst_dp #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 8,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire emst_pkg::emst_cmd_t                  cmd,
  output emst_pkg::emst_stat_t                      stat,
  input  wire logic                                 cfg_clear,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0]      np,
  input  wire logic [$clog2(MAX_DIMS+1)-1:0]        nd,
  input  wire logic signed [COORD_BITS-1:0]         coord,
  output logic                                      out_valid,
  output logic [$clog2(MAX_POINTS)-1:0]             out_child,
  output logic [$clog2(MAX_POINTS)-1:0]             out_parent,
  output logic                                      out_last
);

  localparam int PW     = $clog2(MAX_POINTS);
  localparam int CW     = $clog2(MAX_POINTS+1);
  localparam int DW     = $clog2(MAX_DIMS+1);
  localparam int AW     = $clog2(MAX_POINTS*MAX_DIMS);
  localparam int TW     = AW + 1;
  localparam int MW     = PW + DW;
  localparam int DIST_W = 2*COORD_BITS + $clog2(MAX_DIMS);
  localparam int SQ_W   = 2*COORD_BITS;

  // memories
  logic signed [COORD_BITS-1:0] coord_mem [MAX_POINTS*MAX_DIMS];
  logic [DIST_W-1:0]            bd_mem    [MAX_POINTS];
  logic [PW-1:0]                bp_mem    [MAX_POINTS];
  logic [PW-1:0]                vo_mem    [MAX_POINTS];

  logic [AW-1:0]  lp_r;
  logic [PW-1:0]  p_r, s_r, cur_r, q_r, first_q_r;
  logic [DW-1:0]  j_r;
  logic [AW-1:0]  cur_base_r, q_base_r;
  logic           init_r;
  logic signed [COORD_BITS-1:0] ca_r, cb_r;
  logic signed [COORD_BITS:0]   diff_r;
  logic [SQ_W-1:0]              sq_r;
  logic [DIST_W-1:0]            acc_r;
  logic [DIST_W-1:0]            bd_rd_r;
  logic [PW-1:0]                bp_rd_r, vo_rd_r;
  logic [DIST_W-1:0]            min_r;
  logic [PW-1:0]                minpos_r, minchild_r, minpar_r;

  logic [TW-1:0]   total;
  logic [MW-1:0]   total_m, qprod, cprod;
  logic [PW-1:0]   qval;
  logic [AW-1:0]   addr_a, addr_b;
  logic            take;
  logic [DIST_W-1:0] newd;
  logic [PW-1:0]     newpar;
  logic signed [2*COORD_BITS+1:0] prod_full;

  assign total_m = MW'(np) * MW'(nd);
  assign total   = TW'(total_m);

  // status toward the controller
  assign stat.load_last = (TW'(lp_r) + TW'(1)) == total;
  assign stat.np_one    = (np == CW'(1));
  assign stat.j_last    = (j_r + DW'(1)) == nd;
  assign stat.p_last    = (CW'(p_r) + CW'(1)) == np;
  assign stat.s_last    = (CW'(s_r) + CW'(1)) == np;

  assign qval   = init_r ? p_r : vo_rd_r;
  assign qprod  = MW'(qval) * MW'(nd);
  assign cprod  = MW'(minchild_r) * MW'(nd);
  assign addr_a = cur_base_r + AW'(j_r);
  assign addr_b = q_base_r + AW'(j_r);

  assign take   = init_r || (acc_r < bd_rd_r);
  assign newd   = take ? acc_r : bd_rd_r;
  assign newpar = take ? cur_r : bp_rd_r;
  assign prod_full = diff_r * diff_r;

  // store coordinate beats; read two coordinates per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      coord_mem[lp_r] <= coord;
    end
    ca_r <= coord_mem[addr_a];
    cb_r <= coord_mem[addr_b];
  end

  // best distance and parent stores, read at the candidate point
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      bd_mem[q_r] <= newd;
      bp_mem[q_r] <= newpar;
    end
    bd_rd_r <= bd_mem[q_r];
    bp_rd_r <= bp_mem[q_r];
  end

  // visit order: identity in the first round, swap on each edge
  always_ff @(posedge clk) begin
    if (cmd.cmp && init_r) begin
      vo_mem[p_r] <= p_r;
    end else if (cmd.emit) begin
      vo_mem[minpos_r] <= first_q_r;
    end
    vo_rd_r <= vo_mem[p_r];
  end

  // distance arithmetic pipeline
  always_ff @(posedge clk) begin
    diff_r <= (COORD_BITS+1)'(ca_r) - (COORD_BITS+1)'(cb_r);
    sq_r   <= SQ_W'($unsigned(prod_full));
  end

  // load position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0;
    end else if (cfg_clear) begin
      lp_r <= '0;
    end else if (cmd.load) begin
      lp_r <= stat.load_last ? '0 : lp_r + AW'(1);
    end
  end

  // round control and accumulation
  always_ff @(posedge clk) begin
    if (cmd.round0) begin
      cur_r      <= '0;
      cur_base_r <= '0;
      s_r        <= PW'(1);
      p_r        <= PW'(1);
      init_r     <= 1'b1;
    end
    if (cmd.cap_q) begin
      q_r      <= qval;
      q_base_r <= AW'(qprod);
      j_r      <= '0;
      acc_r    <= '0;
      if (p_r == s_r) begin
        first_q_r <= qval;
      end
    end
    if (cmd.step_j) begin
      acc_r <= acc_r + DIST_W'(sq_r);
      j_r   <= j_r + DW'(1);
    end
    if (cmd.cmp) begin
      if ((p_r == s_r) || (newd < min_r)) begin
        min_r      <= newd;
        minpos_r   <= p_r;
        minchild_r <= q_r;
        minpar_r   <= newpar;
      end
      p_r <= p_r + PW'(1);
    end
    if (cmd.emit) begin
      cur_r      <= minchild_r;
      cur_base_r <= AW'(cprod);
      s_r        <= s_r + PW'(1);
      p_r        <= s_r + PW'(1);
      init_r     <= 1'b0;
    end
  end

  // edge output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
    if (cmd.emit) begin
      out_child  <= minchild_r;
      out_parent <= minpar_r;
      out_last   <= stat.s_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/euclidean_mst_prim.sv */
// ----------------------------------------------------------------------------
// euclidean_mst_prim
// Euclidean minimum spanning tree by dense Prim's algorithm on exact integer
// squared distances; loads coordinates point-major, emits one tree edge per point but point 0.
//
//   channel  ports                                         handshake
//   in       in_coord_value                                start & !busy & !cfg_we
//   out      out_child_index, out_parent_index, out_last_edge   out_valid strobe
//   cfg      cfg_index, cfg_data                           cfg_we
//
// Loading stores one beat whenever start is taken. The last beat starts the
// tree build unless N is 1: round s (s = 1..N-1) visits positions s..N-1,
// each passing states VO and Q, then CA, CB, CC, CD per coordinate (one
// shared subtract/square/accumulate unit, coordinates one at a time) and
// CMP; a round ends with an edge step. busy is high during the build.
// Synchronous reset clears control state; stores hold anything until
// written. The receiver cannot stall, so edges are strobed for one cycle each.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_mst_prim #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 8,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [COORD_BITS-1:0]           in_coord_value,
  output logic                                        out_valid,
  output logic [$clog2(MAX_POINTS)-1:0]               out_child_index,
  output logic [$clog2(MAX_POINTS)-1:0]               out_parent_index,
  output logic                                        out_last_edge,
  input  wire logic                                   cfg_we,
  input  wire logic [emst_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [emst_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int CW = $clog2(MAX_POINTS+1);
  localparam int DW = $clog2(MAX_DIMS+1);

  logic [emst_pkg::PC_W-1:0] pc_r;
  logic [emst_pkg::DC_W-1:0] dc_r;
  logic [CW-1:0] np;
  logic [DW-1:0] nd;
  logic cfg_hit;
  emst_pkg::emst_cmd_t  cmd;
  emst_pkg::emst_stat_t stat;
  logic start_ok;

  assign cfg_hit = cfg_we && ((cfg_index == emst_pkg::REG_POINT_COUNT) ||
                              (cfg_index == emst_pkg::REG_DIM_COUNT));
  assign start_ok = start && !cfg_we;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= emst_pkg::PC_RESET;
      dc_r <= emst_pkg::DC_RESET;
    end else if (cfg_we) begin
      if (cfg_index == emst_pkg::REG_POINT_COUNT) begin
        pc_r <= emst_pkg::PC_W'(cfg_data);
      end else if (cfg_index == emst_pkg::REG_DIM_COUNT) begin
        dc_r <= emst_pkg::DC_W'(cfg_data);
      end
    end
  end

  // clamp counts to the supported range
  always_comb begin
    if (pc_r == '0) begin
      np = CW'(1);
    end else if (32'(pc_r) > MAX_POINTS) begin
      np = CW'(MAX_POINTS);
    end else begin
      np = CW'(pc_r);
    end
    if (dc_r == '0) begin
      nd = DW'(1);
    end else if (32'(dc_r) > MAX_DIMS) begin
      nd = DW'(MAX_DIMS);
    end else begin
      nd = DW'(dc_r);
    end
  end

  emst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_ok),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  emst_dp #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_clear  (cfg_hit),
    .np         (np),
    .nd         (nd),
    .coord      (in_coord_value),
    .out_valid  (out_valid),
    .out_child  (out_child_index),
    .out_parent (out_parent_index),
    .out_last   (out_last_edge)
  );

endmodule

`default_nettype wire
